// ----- src/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// Shadow stamp rasterizer package
// Shared constants, register indexes and mode codes.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int MAX_CHUNK   = 64;
  localparam int MAX_OFFSETS = 64;
  localparam int CELLS       = MAX_CHUNK * MAX_CHUNK;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int OFF_W       = $clog2(MAX_OFFSETS);
  localparam int CNT_W       = OFF_W + 1;
  localparam int FILL_W      = CELL_W + 1;

  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_TERRAIN = 3'd1;
  localparam logic [2:0] MODE_OFFSET  = 3'd2;
  localparam logic [2:0] MODE_EDGE    = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  localparam logic [2:0] REG_CHUNK = 3'd0;
  localparam logic [2:0] REG_BASEX = 3'd1;
  localparam logic [2:0] REG_BASEY = 3'd2;
  localparam logic [2:0] REG_RED   = 3'd3;
  localparam logic [2:0] REG_GREEN = 3'd4;
  localparam logic [2:0] REG_BLUE  = 3'd5;
  localparam logic [2:0] REG_INT   = 3'd6;
  localparam logic [2:0] REG_ROCK  = 3'd7;

endpackage

// ----- src/shadow_stamp_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// Shadow stamp rasterizer
// Stamps graded shadow alphas around edge tiles into a terrain chunk image.
// ----------------------------------------------------------------------------
// Usage: configure through cfg_* (index 0..7) while idle. Input words on
// s_axis carry mode and payload; every accepted word returns one result
// word on m_axis (status, painted flag, color, alpha).
// After reset a clearing pass sweeps the alpha map, one entry a cycle,
// and the first input word is taken only after it ends. A clear word
// (mode 0) runs the same sweep before its result word.
// Terrain, offset and ignored words go straight to the result state; a
// read first passes through a memory read state and a data state. An
// edge word walks the stored offsets through one shared address/compare
// unit and the alpha memory port. For each offset it forms the numerator,
// runs the bit-serial alpha divide, then fetches the offset, reads the
// pixel and writes it.
// The result register holds its word until m_axis_tready; a new input word
// is taken only after the previous result has left.
// ----------------------------------------------------------------------------
module shadow_stamp_rasterizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: terrain_code[7:0], offset_dx[16:8], offset_dy[25:17],
  //        edge_x[49:26], edge_y[73:50], pix_addr[85:74], zero fill
  input  logic [87:0] s_axis_tdata,
  // tuser: mode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: painted[0], pixel_red[8:1], pixel_green[16:9],
  //        pixel_blue[24:17], pixel_alpha[32:25], zero fill
  output logic [39:0] m_axis_tdata,
  // tuser: status[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CW = ssr_pkg::CELL_W;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_OFF   = 11'b00000001000,
    S_ADDR  = 11'b00000010000,
    S_RD    = 11'b00000100000,
    S_WR    = 11'b00001000000,
    S_ALPHA = 11'b00010000000,
    S_RREAD = 11'b00100000000,
    S_RDATA = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [6:0]         side_len;
  logic signed [23:0] base_x, base_y;
  logic [7:0]         shadow_red, shadow_green, shadow_blue, intensity_max, rock_code;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      side_len <= 7'd32; base_x <= '0; base_y <= '0;
      shadow_red <= '0; shadow_green <= '0; shadow_blue <= '0;
      intensity_max <= 8'd255; rock_code <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssr_pkg::REG_CHUNK: side_len      <= cfg_data[6:0];
        ssr_pkg::REG_BASEX: base_x        <= cfg_data;
        ssr_pkg::REG_BASEY: base_y        <= cfg_data;
        ssr_pkg::REG_RED:   shadow_red    <= cfg_data[7:0];
        ssr_pkg::REG_GREEN: shadow_green  <= cfg_data[7:0];
        ssr_pkg::REG_BLUE:  shadow_blue   <= cfg_data[7:0];
        ssr_pkg::REG_INT:   intensity_max <= cfg_data[7:0];
        ssr_pkg::REG_ROCK:  rock_code     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Clamped side and cell count.
  logic [7:0]  side;
  logic [13:0] cells;
  assign side  = (side_len > 7'(ssr_pkg::MAX_CHUNK)) ? 8'(ssr_pkg::MAX_CHUNK)
                                                     : {1'b0, side_len};
  assign cells = {6'd0, side} * {6'd0, side};

  // Memories.
  logic        rock_mem  [ssr_pkg::CELLS];
  logic [7:0]  alpha_mem [ssr_pkg::CELLS];
  logic [17:0] off_mem   [ssr_pkg::MAX_OFFSETS];

  // Job state.
  logic [ssr_pkg::CNT_W-1:0]  offset_count;
  logic [ssr_pkg::FILL_W-1:0] terrain_fill;
  logic                       edges_started, any_stamped;

  // Captured input word.
  logic signed [23:0] ex, ey;
  logic [11:0]        pidx;

  // Edge walk.
  logic [ssr_pkg::CNT_W-1:0] oi;
  logic [CW-1:0]             clr_addr;
  logic [17:0]               off_q;
  logic                      rock_q;
  logic [7:0]                alpha_q;
  logic [CW-1:0]             addr;
  logic                      in_range;
  // Serial divider: quotient of (2*I*(n-i)+(n+1)) / (2*(n+1)).
  logic [16:0] dnum, drem;
  logic [16:0] dquo;
  logic [4:0]  dbit;
  logic [8:0]  stamp_a;

  // Result register.
  logic        r_status;
  logic [7:0]  r_red, r_green, r_blue, r_alpha;

  // Marks the sweep that follows reset, which returns no word.
  logic clr_done_rst;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tuser  = r_status;
  assign m_axis_tdata  = {7'd0, r_alpha, r_blue, r_green, r_red, any_stamped};

  // Shared address unit: world to chunk coordinate with bounds check.
  logic signed [26:0] px, py;
  always_comb begin
    px = 27'(ex) + 27'(signed'(off_q[8:0])) - 27'(base_x);
    py = 27'(ey) + 27'(signed'(off_q[17:9])) - 27'(base_y);
    in_range = (px >= 0) && (py >= 0) && (px < 27'(side)) && (py < 27'(side));
    addr = CW'(py[7:0] * side + {8'd0, px[7:0]});
  end

  // Alpha for offset oi: numerator step in n-i, divided serially.
  logic [ssr_pkg::CNT_W:0]   np1;
  logic [ssr_pkg::CNT_W-1:0] n_left;
  logic [15:0]               num_prod;
  assign np1      = {1'b0, offset_count} + 1'b1;
  assign n_left   = offset_count - oi;
  assign num_prod = {8'd0, intensity_max} * {9'd0, n_left};

  always_ff @(posedge clk) begin
    if (state == S_OFF) off_q <= off_mem[oi[ssr_pkg::OFF_W-1:0]];
    if (state == S_ADDR) begin
      rock_q  <= rock_mem[addr];
      alpha_q <= alpha_mem[addr];
    end
    if (state == S_RREAD) alpha_q <= alpha_mem[pidx];
    if (state == S_CLEAR) alpha_mem[clr_addr] <= '0;
    else if (state == S_WR && in_range && !rock_q && stamp_a != 0 &&
             stamp_a[7:0] > alpha_q)
      alpha_mem[addr] <= stamp_a[7:0];
    if (state == S_IDLE && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == ssr_pkg::MODE_TERRAIN && !edges_started &&
          14'(terrain_fill) < cells)
        rock_mem[terrain_fill[CW-1:0]] <= (s_axis_tdata[7:0] == rock_code);
      if (s_axis_tuser == ssr_pkg::MODE_OFFSET && !edges_started &&
          offset_count < ssr_pkg::CNT_W'(ssr_pkg::MAX_OFFSETS))
        off_mem[offset_count[ssr_pkg::OFF_W-1:0]] <= s_axis_tdata[25:8];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_addr <= '0; m_axis_tvalid <= 1'b0;
      offset_count <= '0; terrain_fill <= '0;
      edges_started <= 1'b0; any_stamped <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CW'(ssr_pkg::CELLS - 1)) state <= S_OUT;
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          ex    <= s_axis_tdata[49:26]; ey <= s_axis_tdata[73:50];
          pidx  <= s_axis_tdata[85:74];
          r_status <= 1'b1; r_red <= '0; r_green <= '0; r_blue <= '0; r_alpha <= '0;
          state <= S_OUT;
          case (s_axis_tuser)
            ssr_pkg::MODE_CLEAR: begin
              offset_count <= '0; terrain_fill <= '0;
              edges_started <= 1'b0; any_stamped <= 1'b0;
              r_status <= 1'b0; clr_addr <= '0; state <= S_CLEAR;
            end
            ssr_pkg::MODE_TERRAIN:
              if (!edges_started && 14'(terrain_fill) < cells) begin
                terrain_fill <= terrain_fill + 1'b1; r_status <= 1'b0;
              end
            ssr_pkg::MODE_OFFSET:
              if (!edges_started &&
                  offset_count < ssr_pkg::CNT_W'(ssr_pkg::MAX_OFFSETS)) begin
                offset_count <= offset_count + 1'b1; r_status <= 1'b0;
              end
            ssr_pkg::MODE_EDGE:
              if (14'(terrain_fill) >= cells) begin
                edges_started <= 1'b1; r_status <= 1'b0; oi <= '0;
                if (offset_count != 0) state <= S_ALPHA;
              end
            ssr_pkg::MODE_READ:
              if (14'(s_axis_tdata[85:74]) < cells) begin
                r_status <= 1'b0; state <= S_RREAD;
              end
            default: ;
          endcase
        end
        S_ALPHA: begin
          // Numerator for this offset, then serial restoring divide.
          dnum <= {num_prod, 1'b0} + {9'd0, np1};
          drem <= '0; dquo <= '0; dbit <= 5'd16;
          state <= S_DIV;
        end
        S_DIV: begin
          if ({drem[15:0], dnum[dbit]} >= 17'({np1, 1'b0})) begin
            drem <= {drem[15:0], dnum[dbit]} - 17'({np1, 1'b0});
            dquo[dbit] <= 1'b1;
          end else drem <= {drem[15:0], dnum[dbit]};
          if (dbit == 0) state <= S_OFF;
          else dbit <= dbit - 1'b1;
        end
        S_OFF: state <= S_ADDR;
        S_ADDR: begin
          stamp_a <= (dquo > 17'd255) ? 9'd255 : dquo[8:0];
          state <= S_RD;
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (in_range && !rock_q && stamp_a != 0 && stamp_a[7:0] > alpha_q)
            any_stamped <= 1'b1;
          oi <= oi + 1'b1;
          state <= (oi + 1'b1 == offset_count) ? S_OUT : S_ALPHA;
        end
        S_RREAD: state <= S_RDATA;
        S_RDATA: begin
          r_alpha <= alpha_q;
          if (alpha_q != 0) begin
            r_red <= shadow_red; r_green <= shadow_green; r_blue <= shadow_blue;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // The reset sweep produces no result word.
          m_axis_tvalid <= !clr_done_rst;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_done_rst <= 1'b1;
    else if (state == S_OUT) clr_done_rst <= 1'b0;
  end

endmodule

// ----- src/ssr_checker.sv -----
// ----------------------------------------------------------------------------
// Shadow stamp rasterizer checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module ssr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A waiting result holds its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // No input is taken while a result waits.
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  // An accepted input never yields a result in the very next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

  // Unused padding stays zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("padding not zero");

  // A valid result always carries a known status.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !$isunknown(m_axis_tuser))
    else $error("status unknown on a valid result");

endmodule

bind shadow_stamp_rasterizer_unit ssr_checker u_ssr_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
